// ===== rtl/sstk_pkg.sv =====
// Shared types, constants and the saturating add for the space-saving top-k table.
// Used by every module of the block; depends on nothing else.
package sstk_pkg;

  localparam int KEY_W   = 64;
  localparam int CNT_W   = 40;
  localparam int INC_W   = 16;
  localparam int RCNT_W  = 7;
  localparam int RANK_W  = 6;
  localparam int CAP_W   = 9;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_WAIT,
    ST_INS_WRITE,
    ST_Q_SCAN,
    ST_Q_WAIT,
    ST_Q_PICK,
    ST_Q_EMIT
  } state_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [INC_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-INC_W+1){1'b0}}, b};
    return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/sstk_mem.sv =====
// Single-port-write, single-port-read table memory for keys, counts and errors.
// Depends on sstk_pkg for field widths.
module sstk_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [sstk_pkg::KEY_W-1:0] wkey,
  input  logic [sstk_pkg::CNT_W-1:0] wcnt,
  input  logic [sstk_pkg::CNT_W-1:0] werr,
  input  logic [AW-1:0]           raddr,
  output logic [sstk_pkg::KEY_W-1:0] rkey,
  output logic [sstk_pkg::CNT_W-1:0] rcnt,
  output logic [sstk_pkg::CNT_W-1:0] rerr
);
  import sstk_pkg::*;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [CNT_W-1:0] cnt_mem [DEPTH];
  logic [CNT_W-1:0] err_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      cnt_mem[waddr] <= wcnt;
      err_mem[waddr] <= werr;
    end
    rkey <= key_mem[raddr];
    rcnt <= cnt_mem[raddr];
    rerr <= err_mem[raddr];
  end

endmodule

// ===== rtl/space_saving_top_k_table.sv =====
// Space-saving heavy-hitter table: top level with control sequencer.
// Depends on sstk_pkg and instantiates sstk_mem.
//
// The table keeps up to slots_in_use entries (key, count, error) in one
// synchronous memory read one entry a cycle. An insert (cmd 0) sweeps the
// filled entries looking for its key while tracking the lowest count; it
// then writes the entry back and gives no result. A query (cmd 1) makes one
// selection sweep over the filled entries for each reported rank, picking
// the highest count minus error that ranks below the previous pick (lower
// slot on ties), and offers each entry as one output transfer with its rank
// and a last flag on the final one. Because the ranking order is strict,
// remembering the previous pick stands in for a per-entry reported mark. One
// item is handled at a time; the capacity register is written only while the
// block is idle, a write offered alongside an item is taken first, and a
// lower capacity drops the entries above it at the write.
module space_saving_top_k_table #(
  parameter int TABLE_ENTRIES = 256,
  parameter int REPORT_LIMIT  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sstk_pkg::CAP_W-1:0]    cfg_slots_in_use,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [sstk_pkg::KEY_W-1:0]    in_item_key,
  input  logic [sstk_pkg::INC_W-1:0]    in_increment,
  input  logic [sstk_pkg::RCNT_W-1:0]   in_report_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sstk_pkg::KEY_W-1:0]    out_entry_key,
  output logic [sstk_pkg::CNT_W-1:0]    out_entry_count,
  output logic [sstk_pkg::RANK_W-1:0]   out_entry_rank,
  output logic                          out_last_entry
);
  import sstk_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int NW = AW + 1;
  localparam logic [NW-1:0] ENTRIES_N = NW'(TABLE_ENTRIES);
  localparam logic [RCNT_W-1:0] LIMIT_R = RCNT_W'(REPORT_LIMIT);

  state_t state_r, state_nxt;

  // Capacity after clamping, held ready for use.
  logic [NW-1:0] cap_r;
  logic [NW-1:0] filled_r, filled_nxt;
  logic [NW-1:0] cap_wr;
  logic [NW-1:0] wcap_ext;

  logic [KEY_W-1:0] key_r;
  logic [INC_W-1:0] inc_r;
  logic [RCNT_W-1:0] want_r;
  logic [RCNT_W-1:0] rank_r;
  logic [RCNT_W-1:0] want_lim;
  logic [RCNT_W-1:0] want_nxt;

  // Sweep address and pipeline of the address presented to the memory.
  logic [NW-1:0] scan_r;
  logic          rd_v_r;
  logic [AW-1:0] rd_a_r;

  logic          hit_r;
  logic [AW-1:0] hit_a_r;
  logic [CNT_W-1:0] hit_c_r;
  logic [CNT_W-1:0] hit_e_r;
  logic          best_v_r;
  logic [AW-1:0] best_a_r;
  logic [CNT_W-1:0] best_c_r;   // min count on insert, best score on query
  logic [KEY_W-1:0] best_k_r;
  logic [CNT_W-1:0] best_cnt_r;

  // The entry reported last; only entries ranking below it are eligible.
  logic          prev_v_r;
  logic [AW-1:0] prev_a_r;
  logic [CNT_W-1:0] prev_s_r;
  logic          eligible;

  logic [KEY_W-1:0] rkey;
  logic [CNT_W-1:0] rcnt, rerr, score;
  logic          we;
  logic [AW-1:0] waddr;
  logic [KEY_W-1:0] wkey;
  logic [CNT_W-1:0] wcnt, werr;
  logic          scan_more;
  logic          in_acc;

  sstk_mem #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wkey, .wcnt, .werr,
    .raddr(scan_r[AW-1:0]), .rkey, .rcnt, .rerr
  );

  assign scan_more = (scan_r < filled_r) &&
                     (state_r == ST_INS_SCAN || state_r == ST_Q_SCAN);
  assign score = (rcnt >= rerr) ? rcnt - rerr : '0;
  assign eligible = !prev_v_r || (score < prev_s_r) ||
                    (score == prev_s_r && rd_a_r > prev_a_r);

  always_comb begin
    wcap_ext = NW'(cfg_slots_in_use);
    if (cfg_slots_in_use == '0) cap_wr = NW'(1);
    else if ({{NW{1'b0}}, cfg_slots_in_use} > {{CAP_W{1'b0}}, ENTRIES_N}) cap_wr = ENTRIES_N;
    else cap_wr = wcap_ext;
  end

  // Number of entries a query reports: its request, limited twice.
  always_comb begin
    want_lim = (in_report_count > LIMIT_R) ? LIMIT_R : in_report_count;
    if ({{NW{1'b0}}, want_lim} > {{RCNT_W{1'b0}}, filled_r}) want_nxt = RCNT_W'(filled_r);
    else want_nxt = want_lim;
  end

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign in_acc    = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_INSERT) state_nxt = ST_INS_SCAN;
          else if (in_report_count == '0 || filled_r == '0) state_nxt = ST_IDLE;
          else state_nxt = ST_Q_SCAN;
        end
      end
      ST_INS_SCAN:  if (!scan_more) state_nxt = ST_INS_WAIT;
      ST_INS_WAIT:  state_nxt = ST_INS_WRITE;
      ST_INS_WRITE: state_nxt = ST_IDLE;
      ST_Q_SCAN:    if (!scan_more) state_nxt = ST_Q_WAIT;
      ST_Q_WAIT:    state_nxt = ST_Q_PICK;
      ST_Q_PICK:    state_nxt = ST_Q_EMIT;
      ST_Q_EMIT: begin
        if (out_ready) state_nxt = (rank_r + 1'b1 == want_r) ? ST_IDLE : ST_Q_SCAN;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Write-back of an insert.
  always_comb begin
    we = (state_r == ST_INS_WRITE);
    waddr = hit_a_r;
    wkey = key_r;
    wcnt = sat_add(hit_c_r, inc_r);
    werr = hit_e_r;
    filled_nxt = filled_r;
    if (!hit_r) begin
      if (filled_r < cap_r) begin
        waddr = filled_r[AW-1:0];
        wcnt = sat_add('0, inc_r);
        werr = '0;
        filled_nxt = filled_r + 1'b1;
      end else begin
        waddr = best_a_r;
        werr = best_c_r;
        wcnt = sat_add(best_c_r, inc_r);
      end
    end
  end

  assign out_valid       = (state_r == ST_Q_EMIT);
  assign out_entry_key   = best_k_r;
  assign out_entry_count = best_cnt_r;
  assign out_entry_rank  = rank_r[RANK_W-1:0];
  assign out_last_entry  = (rank_r + 1'b1 == want_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cap_r    <= ENTRIES_N;
      filled_r <= '0;
      rd_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= scan_more;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cap_wr;
        if (filled_r > cap_wr) filled_r <= cap_wr;
      end else if (we) begin
        filled_r <= filled_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= scan_r[AW-1:0];
    if (scan_more) scan_r <= scan_r + 1'b1;
    if (in_acc) begin
      key_r    <= in_item_key;
      inc_r    <= in_increment;
      want_r   <= want_nxt;
      rank_r   <= '0;
      prev_v_r <= 1'b0;
    end
    if (state_r == ST_Q_PICK) begin
      prev_v_r <= 1'b1;
      prev_a_r <= best_a_r;
      prev_s_r <= best_c_r;
    end
    if (in_acc || (state_r == ST_Q_EMIT && out_ready)) begin
      scan_r   <= '0;
      hit_r    <= 1'b0;
      best_v_r <= 1'b0;
    end
    if (state_r == ST_Q_EMIT && out_ready) rank_r <= rank_r + 1'b1;
    if (rd_v_r) begin
      if (state_r == ST_INS_SCAN || state_r == ST_INS_WAIT) begin
        if (!hit_r && rkey == key_r) begin
          hit_r <= 1'b1; hit_a_r <= rd_a_r; hit_c_r <= rcnt; hit_e_r <= rerr;
        end
        if (!best_v_r || rcnt < best_c_r) begin
          best_v_r <= 1'b1; best_a_r <= rd_a_r; best_c_r <= rcnt;
        end
      end else if (eligible && (!best_v_r || score > best_c_r)) begin
        best_v_r <= 1'b1; best_a_r <= rd_a_r; best_c_r <= score;
        best_k_r <= rkey; best_cnt_r <= rcnt;
      end
    end
  end

  // A result only appears for a query that wants at least one entry.
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> want_r != '0) else $error("result without a request");
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= cap_r) else $error("fill count exceeds capacity");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_entry_key) && $stable(out_entry_rank))
    else $error("result changed while stalled");
  a_pick_mark: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_Q_PICK |-> best_v_r) else $error("no entry chosen");

endmodule

// ===== tb/tb_space_saving_top_k_table.sv =====
// Self-checking testbench for the space-saving top-k heavy-hitter table.
// Depends on sstk_pkg and space_saving_top_k_table; it drives random and directed
// insert and query transfers and checks every reported entry against its own table model.
`timescale 1ns / 100ps

module tb_space_saving_top_k_table;
  import sstk_pkg::*;

  localparam int TBL_N  = 256;
  localparam int RPT_LIM = 64;

  typedef struct {
    logic              cmd;
    logic [KEY_W-1:0]  key;
    logic [INC_W-1:0]  inc;
    logic [RCNT_W-1:0] rcnt;
  } req_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  cnt;
    logic [RANK_W-1:0] rank;
    logic              last;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_slots_in_use = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_INSERT;
  logic [KEY_W-1:0] in_item_key = '0;
  logic [INC_W-1:0] in_increment = '0;
  logic [RCNT_W-1:0] in_report_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KEY_W-1:0] out_entry_key;
  logic [CNT_W-1:0] out_entry_count;
  logic [RANK_W-1:0] out_entry_rank;
  logic out_last_entry;

  space_saving_top_k_table dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_slots_in_use(cfg_slots_in_use),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_item_key(in_item_key), .in_increment(in_increment),
    .in_report_count(in_report_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_entry_key(out_entry_key),
    .out_entry_count(out_entry_count), .out_entry_rank(out_entry_rank),
    .out_last_entry(out_last_entry)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The testbench's own copy of the table and its capacity setting.
  logic [KEY_W-1:0] tbl_key [TBL_N];
  logic [CNT_W-1:0] tbl_cnt [TBL_N];
  logic [CNT_W-1:0] tbl_err [TBL_N];
  int unsigned filled;
  int unsigned capacity;

  entry_t pending_entries[$];
  int unsigned mismatches;
  int unsigned entries_seen;
  int unsigned queries_sent;
  int unsigned inserts_sent;

  // Idling control for both sides; a quiet stretch switches idling off.
  bit quiet_phase;
  bit hold_receiver;
  bit hold_requested;

  // Recent keys are reused so that inserts hit existing entries often.
  logic [KEY_W-1:0] key_pool[$];

  function automatic int unsigned clamp_cap(input logic [CAP_W-1:0] v);
    if (v == 0) return 1;
    if (v > TBL_N) return TBL_N;
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] a,
                                               input logic [INC_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + b;
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  task automatic apply_capacity(input logic [CAP_W-1:0] v);
    capacity = clamp_cap(v);
    if (filled > capacity) filled = capacity;
  endtask

  // Updates the table for an insert; a query queues the entries it should report.
  task automatic predict_table(input req_t r);
    int unsigned n, i, best, want, rk;
    logic [CNT_W-1:0] m, v, best_v;
    bit marked [TBL_N];
    bit found;
    entry_t e;
    n = (filled < capacity) ? filled : capacity;
    if (r.cmd == CMD_INSERT) begin
      for (i = 0; i < n; i++) begin
        if (tbl_key[i] == r.key) begin
          tbl_cnt[i] = add_sat(tbl_cnt[i], r.inc);
          return;
        end
      end
      if (n < capacity) begin
        tbl_key[n] = r.key;
        tbl_cnt[n] = add_sat('0, r.inc);
        tbl_err[n] = '0;
        filled = n + 1;
        return;
      end
      best = 0;
      for (i = 1; i < n; i++) if (tbl_cnt[i] < tbl_cnt[best]) best = i;
      m = tbl_cnt[best];
      tbl_key[best] = r.key;
      tbl_err[best] = m;
      tbl_cnt[best] = add_sat(m, r.inc);
      return;
    end
    want = (r.rcnt > RPT_LIM) ? RPT_LIM : r.rcnt;
    if (want > n) want = n;
    for (i = 0; i < TBL_N; i++) marked[i] = 1'b0;
    for (rk = 0; rk < want; rk++) begin
      found = 1'b0;
      best = 0;
      best_v = '0;
      for (i = 0; i < n; i++) begin
        if (!marked[i]) begin
          v = (tbl_cnt[i] >= tbl_err[i]) ? tbl_cnt[i] - tbl_err[i] : '0;
          if (!found || v > best_v) begin
            found = 1'b1;
            best = i;
            best_v = v;
          end
        end
      end
      marked[best] = 1'b1;
      e.key = tbl_key[best];
      e.cnt = tbl_cnt[best];
      e.rank = rk[RANK_W-1:0];
      e.last = (rk + 1 == want);
      pending_entries.insert(pending_entries.size(), e);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int unsigned k;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_requested && !hold_receiver) begin
        hold_receiver <= 1'b1;
        out_ready <= 1'b0;
        for (k = 0; k < 400; k++) @(posedge clk);
        hold_receiver <= 1'b0;
        hold_requested <= 1'b0;
      end
      out_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 34);
    end
  end

  // Result checker: sampled at the edge, compared with the oldest expectation.
  always @(posedge clk) begin
    entry_t e;
    if (rst_n && out_valid && out_ready) begin
      entries_seen++;
      if (pending_entries.size() == 0) begin
        report_mismatch("unexpected entry_key", out_entry_key, '0);
      end else begin
        e = pending_entries.pop_front();
        if (out_entry_key !== e.key) report_mismatch("entry_key", out_entry_key, e.key);
        if (out_entry_count !== e.cnt)
          report_mismatch("entry_count", KEY_W'(out_entry_count), KEY_W'(e.cnt));
        if (out_entry_rank !== e.rank)
          report_mismatch("entry_rank", KEY_W'(out_entry_rank), KEY_W'(e.rank));
        if (out_last_entry !== e.last)
          report_mismatch("last_entry", KEY_W'(out_last_entry), KEY_W'(e.last));
      end
    end
  end

  // Withdraws the offer so that nothing further is taken while the sender waits.
  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one transfer, holding it steady until the block takes it.
  task automatic send_item(input req_t r);
    if (!quiet_phase && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 34) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_item_key <= r.key;
    in_increment <= r.inc;
    in_report_count <= r.rcnt;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_table(r);
    if (r.cmd == CMD_QUERY) queries_sent++;
    else inserts_sent++;
  endtask

  // Waits for every expected entry, then lets a busy insert finish before a write.
  task automatic drain();
    int unsigned k;
    stop_input();
    while (pending_entries.size() != 0) @(posedge clk);
    for (k = 0; k < 2 * TBL_N + 16; k++) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_slots_in_use <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    apply_capacity(v);
  endtask

  function automatic req_t random_req(input int unsigned query_pct);
    req_t r;
    r.cmd = ($urandom_range(99) < query_pct) ? CMD_QUERY : CMD_INSERT;
    if (key_pool.size() != 0 && $urandom_range(99) < 60)
      r.key = key_pool[$urandom_range(key_pool.size() - 1)];
    else begin
      r.key = {$urandom, $urandom};
      if (key_pool.size() < 24) key_pool.insert(key_pool.size(), r.key);
      else key_pool[$urandom_range(23)] = r.key;
    end
    case ($urandom_range(9))
      0: r.inc = '0;
      1: r.inc = '1;
      default: r.inc = INC_W'($urandom_range(1, 300));
    endcase
    r.rcnt = ($urandom_range(9) == 0) ? RCNT_W'($urandom) : RCNT_W'($urandom_range(0, 12));
    return r;
  endfunction

  // Directed rows: a fresh table at capacity 3, so extremes and ties are easy to read.
  typedef struct {
    req_t   r;
    bit     typed;
    entry_t want;
  } row_t;

  row_t rows[$];

  task automatic add_row(input logic cmd, input logic [KEY_W-1:0] key,
                         input logic [INC_W-1:0] inc, input logic [RCNT_W-1:0] rcnt);
    row_t w;
    w.r = '{cmd, key, inc, rcnt};
    w.typed = 1'b0;
    w.want = '{'0, '0, '0, 1'b0};
    rows.insert(rows.size(), w);
  endtask

  initial begin
    req_t r;
    row_t w;
    entry_t e;
    int unsigned i, k, phase;
    logic [CAP_W-1:0] caps [6];
    quiet_phase = 1'b0;
    hold_receiver = 1'b0;
    hold_requested = 1'b0;
    mismatches = 0;
    entries_seen = 0;
    queries_sent = 0;
    inserts_sent = 0;
    filled = 0;
    capacity = TBL_N;
    for (i = 0; i < TBL_N; i++) begin
      tbl_key[i] = '0;
      tbl_cnt[i] = '0;
      tbl_err[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Query of an empty table right after reset gives nothing.
    add_row(CMD_QUERY, '1, '1, 7'd64);
    add_row(CMD_INSERT, '1, 16'hFFFF, 7'd0);
    add_row(CMD_INSERT, '0, 16'd0, 7'h7F);
    add_row(CMD_INSERT, 64'h5555_AAAA_5555_AAAA, 16'd1, 7'd0);
    add_row(CMD_QUERY, '0, '0, 7'd0);
    add_row(CMD_QUERY, '0, '0, 7'd1);
    // The all-ones key leads with the biggest increment.
    rows[$].typed = 1'b1;
    rows[$].want = '{'1, 40'd65535, 6'd0, 1'b1};
    add_row(CMD_INSERT, 64'hAAAA_5555_AAAA_5555, 16'd2, 7'd0);
    add_row(CMD_QUERY, '1, '1, 7'h7F);
    add_row(CMD_INSERT, '0, 16'd5, 7'd0);
    add_row(CMD_INSERT, 64'h1234, 16'd7, 7'd0);
    add_row(CMD_QUERY, '0, '0, 7'd3);
    // Pile the largest increments onto one entry.
    for (k = 0; k < 6; k++) add_row(CMD_INSERT, '1, 16'hFFFF, 7'd0);
    add_row(CMD_QUERY, '0, '0, 7'd2);
    add_row(CMD_INSERT, 64'h8000_0000_0000_0001, 16'd3, 7'd0);
    add_row(CMD_QUERY, '0, '0, 7'd65);

    write_capacity(9'd3);
    foreach (rows[i]) begin
      w = rows[i];
      if (w.typed) begin
        // The typed row sets the one expectation by hand.
        stop_input();
        while (pending_entries.size() != 0) @(posedge clk);
        send_item(w.r);
        e = pending_entries.pop_back();
        pending_entries.insert(pending_entries.size(), w.want);
      end else
        send_item(w.r);
    end

    // Random phases over a range of capacities, the extremes among them.
    caps = '{9'd0, 9'd511, 9'd1, 9'd256, 9'd5, 9'd40};
    for (phase = 0; phase < 6; phase++) begin
      write_capacity(caps[phase]);
      quiet_phase = (phase == 3);
      for (k = 0; k < 32; k++) begin
        r = random_req(15);
        send_item(r);
        if (phase == 2 && k == 10) begin
          // Long receiver hold-off while several queries pile up behind it.
          hold_requested = 1'b1;
          for (i = 0; i < 3; i++) send_item('{CMD_QUERY, '0, '0, 7'd8});
        end
        if (phase == 4 && k == 16) begin
          // Sender pauses until the table has reported everything due.
          stop_input();
          while (pending_entries.size() != 0) @(posedge clk);
        end
      end
      send_item('{CMD_QUERY, '0, '0, 7'd64});
    end

    drain();
    $display("covered %0d inserts and %0d queries with %0d reported entries,",
             inserts_sent, queries_sent, entries_seen);
    $display("over capacities from one slot to the full table, with hold-offs on both sides");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard limit well beyond the slowest correct run.
  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
